/* rtl/thrcol_pkg.sv */
package thrcol_pkg;

  // default sizes of the effectiveness matrix
  localparam int MAX_COLUMNS_DEF   = 16;
  localparam int MAX_THRUSTERS_DEF = 16;

  // one lane per output row: three moment rows, then three force rows
  localparam int NLANE     = 6;
  localparam int MAG_W     = 47;
  localparam int ROOT_W    = 32;
  localparam int RAD_W     = 64;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = ROOT_W + 1;
  localparam int QUO_W     = 32;
  localparam int MOM_SHIFT = 15;
  localparam int FRC_SHIFT = 25;

  // status codes
  localparam logic [2:0] ST_WRITTEN     = 3'd0;
  localparam logic [2:0] ST_ZERO_AXIS   = 3'd1;
  localparam logic [2:0] ST_ZERO_COEF   = 3'd2;
  localparam logic [2:0] ST_BEYOND_CNT  = 3'd3;
  localparam logic [2:0] ST_BEYOND_COLS = 3'd4;

  // configuration register indexes
  localparam logic REG_START_COLUMN   = 1'b0;
  localparam logic REG_THRUSTER_COUNT = 1'b1;

  typedef struct packed {
    logic [3:0]         thruster_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [15:0] coef;
  } item_t;

  typedef struct packed {
    logic [4:0]         column;
    logic [2:0]         status;
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } result_t;

  // what travels beside the arithmetic to the output
  typedef struct packed {
    logic [4:0]       column;
    logic [2:0]       status;
    logic [NLANE-1:0] neg;
  } tag_t;

  // what travels beside the square root
  typedef struct packed {
    tag_t                        tag;
    logic [NLANE-1:0][MAG_W-1:0] mag;
  } sqside_t;

endpackage

/* rtl/thrcol_sqrt.sv */
module thrcol_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [thrcol_pkg::RAD_W-1:0] radicand,
  input  thrcol_pkg::sqside_t          in_side,
  output logic                         out_valid,
  output logic [thrcol_pkg::ROOT_W-1:0] root,
  output thrcol_pkg::sqside_t          out_side
);

  localparam int STEPS = thrcol_pkg::ROOT_W;
  localparam int W     = thrcol_pkg::RAD_W;

  logic                valid_s [STEPS+1];
  logic [W-1:0]        rem_s   [STEPS+1];
  logic [W-1:0]        root_s  [STEPS+1];
  thrcol_pkg::sqside_t side_s  [STEPS+1];

  assign valid_s[0] = in_valid;
  assign rem_s[0]   = radicand;
  assign root_s[0]  = '0;
  assign side_s[0]  = in_side;

  // one result bit per stage, digit-by-digit root
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0] trial;
    logic [W-1:0] rem_next;
    logic [W-1:0] root_next;

    always_comb begin
      trial = root_s[k] + BIT;
      if (rem_s[k] >= trial) begin
        rem_next  = rem_s[k] - trial;
        root_next = (root_s[k] >> 1) + BIT;
      end else begin
        rem_next  = rem_s[k];
        root_next = root_s[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_s[k+1] <= 1'b0;
      end else begin
        valid_s[k+1] <= valid_s[k];
      end
      rem_s[k+1]  <= rem_next;
      root_s[k+1] <= root_next;
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_valid = valid_s[STEPS];
  assign root      = root_s[STEPS][thrcol_pkg::ROOT_W-1:0];
  assign out_side  = side_s[STEPS];

  // a nonzero axis has length of at least one raw unit
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_side.tag.status == thrcol_pkg::ST_WRITTEN |-> root >= 32'd65536)
    else $error("root below one raw unit for a written column");

endmodule

/* rtl/thrcol_div.sv */
module thrcol_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  input  logic [thrcol_pkg::NLANE-1:0][thrcol_pkg::NUM_W-1:0] num,
  input  logic [thrcol_pkg::DEN_W-1:0]                   den,
  input  thrcol_pkg::tag_t                               in_tag,
  output logic                                           out_valid,
  output logic [thrcol_pkg::NLANE-1:0][thrcol_pkg::QUO_W-1:0] quo,
  output thrcol_pkg::tag_t                               out_tag
);

  localparam int STEPS = thrcol_pkg::QUO_W;
  localparam int NW    = thrcol_pkg::NUM_W;
  localparam int NL    = thrcol_pkg::NLANE;

  logic                         valid_s [STEPS+1];
  logic [NL-1:0][NW-1:0]        rem_s   [STEPS+1];
  logic [NL-1:0][STEPS-1:0]     quo_s   [STEPS+1];
  logic [thrcol_pkg::DEN_W-1:0] den_s   [STEPS+1];
  thrcol_pkg::tag_t             tag_s   [STEPS+1];

  assign valid_s[0] = in_valid;
  assign rem_s[0]   = num;
  assign quo_s[0]   = '0;
  assign den_s[0]   = den;
  assign tag_s[0]   = in_tag;

  // restoring division, one quotient bit per stage in every lane
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = STEPS - 1 - k;
    logic [NW:0]           shifted;
    logic [NL-1:0][NW-1:0] rem_next;
    logic [NL-1:0][STEPS-1:0] quo_next;

    always_comb begin
      shifted = (NW + 1)'(den_s[k]) << SH;
      for (int j = 0; j < NL; j++) begin
        if ({1'b0, rem_s[k][j]} >= shifted) begin
          rem_next[j] = rem_s[k][j] - shifted[NW-1:0];
          quo_next[j] = {quo_s[k][j][STEPS-2:0], 1'b1};
        end else begin
          rem_next[j] = rem_s[k][j];
          quo_next[j] = {quo_s[k][j][STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_s[k+1] <= 1'b0;
      end else begin
        valid_s[k+1] <= valid_s[k];
      end
      rem_s[k+1] <= rem_next;
      quo_s[k+1] <= quo_next;
      den_s[k+1] <= den_s[k];
      tag_s[k+1] <= tag_s[k];
    end
  end

  assign out_valid = valid_s[STEPS];
  assign quo       = quo_s[STEPS];
  assign out_tag   = tag_s[STEPS];

endmodule

/* rtl/thruster_effectiveness_column_top.sv */
// Thruster effectiveness column.
// An item (one thruster: index, position, raw thrust axis, coefficient) is
// taken at a rising edge with start high and busy low. busy never rises, so
// a new item may be started in every cycle: one item per cycle sustained.
// Each item gives exactly one result on the result port, marked by done for
// a single cycle. Its path runs through the 32-stage square root of the axis
// length and then the 32-stage divider that scales all six rows at once.
// The result holds the matrix column, a status and the moment and force
// rows in Q16.16; for any status other than written the rows are zero.
// The receiver cannot stall: a result must be taken in its done cycle.
// Two registers (start column, thruster count) are written over the
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is
// always high. Write them only while no item is in flight.
// Synchronous reset clears both registers and empties the pipeline; items
// in flight at reset are dropped.
module thruster_effectiveness_column_top #(
  parameter int MAX_COLUMNS   = thrcol_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_THRUSTERS = thrcol_pkg::MAX_THRUSTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  thrcol_pkg::item_t   item,
  output logic                done,
  output thrcol_pkg::result_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);

  localparam int NL  = thrcol_pkg::NLANE;
  localparam int LAT = 4 + thrcol_pkg::ROOT_W + 1 + thrcol_pkg::QUO_W + 1;

  logic [4:0] start_column;
  logic [4:0] thruster_count;
  logic       accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_column   <= '0;
      thruster_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        thrcol_pkg::REG_START_COLUMN:   start_column   <= cfg_data;
        thrcol_pkg::REG_THRUSTER_COUNT: thruster_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the item against the registers
  logic [5:0] count_eff;
  logic [5:0] col_sum;
  logic [2:0] status_in;

  always_comb begin
    count_eff = {1'b0, thruster_count};
    if (count_eff > 6'(MAX_THRUSTERS)) begin
      count_eff = 6'(MAX_THRUSTERS);
    end
    col_sum = 6'(start_column) + 6'(item.thruster_index);
    priority if (6'(item.thruster_index) >= count_eff) begin
      status_in = thrcol_pkg::ST_BEYOND_CNT;
    end else if (col_sum >= 6'(MAX_COLUMNS)) begin
      status_in = thrcol_pkg::ST_BEYOND_COLS;
    end else if (item.dir_x == '0 && item.dir_y == '0 && item.dir_z == '0) begin
      status_in = thrcol_pkg::ST_ZERO_AXIS;
    end else if (item.coef == '0) begin
      status_in = thrcol_pkg::ST_ZERO_COEF;
    end else begin
      status_in = thrcol_pkg::ST_WRITTEN;
    end
  end

  // stage a: input register
  logic              a_valid;
  thrcol_pkg::item_t a_item;
  logic [4:0]        a_column;
  logic [2:0]        a_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_item   <= item;
    a_column <= col_sum[4:0];
    a_status <= status_in;
  end

  // stage b: squares, cross terms, coefficient times axis
  logic               b_valid;
  logic [31:0]        b_sq [3];
  logic signed [31:0] b_xp [6];
  logic signed [31:0] b_fd [3];
  logic signed [15:0] b_coef;
  logic [4:0]         b_column;
  logic [2:0]         b_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_sq[0]  <= a_item.dir_x * a_item.dir_x;
    b_sq[1]  <= a_item.dir_y * a_item.dir_y;
    b_sq[2]  <= a_item.dir_z * a_item.dir_z;
    b_xp[0]  <= a_item.pos_y * a_item.dir_z;
    b_xp[1]  <= a_item.pos_z * a_item.dir_y;
    b_xp[2]  <= a_item.pos_z * a_item.dir_x;
    b_xp[3]  <= a_item.pos_x * a_item.dir_z;
    b_xp[4]  <= a_item.pos_x * a_item.dir_y;
    b_xp[5]  <= a_item.pos_y * a_item.dir_x;
    b_fd[0]  <= a_item.coef * a_item.dir_x;
    b_fd[1]  <= a_item.coef * a_item.dir_y;
    b_fd[2]  <= a_item.coef * a_item.dir_z;
    b_coef   <= a_item.coef;
    b_column <= a_column;
    b_status <= a_status;
  end

  // stage c: squared length and cross product
  logic               c_valid;
  logic [31:0]        c_s;
  logic signed [32:0] c_cr [3];
  logic signed [31:0] c_fd [3];
  logic signed [15:0] c_coef;
  logic [4:0]         c_column;
  logic [2:0]         c_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_s      <= b_sq[0] + b_sq[1] + b_sq[2];
    c_cr[0]  <= 33'(b_xp[0]) - 33'(b_xp[1]);
    c_cr[1]  <= 33'(b_xp[2]) - 33'(b_xp[3]);
    c_cr[2]  <= 33'(b_xp[4]) - 33'(b_xp[5]);
    c_fd     <= b_fd;
    c_coef   <= b_coef;
    c_column <= b_column;
    c_status <= b_status;
  end

  // stage d: coefficient times cross product, all six rows split into sign and magnitude
  logic signed [48:0]   mp [3];
  logic [48:0]          mp_abs [3];
  logic [31:0]          fd_abs [3];
  thrcol_pkg::sqside_t  d_side_next;
  logic                 d_valid;
  logic [thrcol_pkg::RAD_W-1:0] d_rad;
  thrcol_pkg::sqside_t  d_side;

  always_comb begin
    d_side_next.tag.column = c_column;
    d_side_next.tag.status = c_status;
    for (int j = 0; j < 3; j++) begin
      mp[j]     = 49'(c_coef) * 49'(c_cr[j]);
      mp_abs[j] = mp[j][48] ? 49'(-mp[j]) : 49'(mp[j]);
      fd_abs[j] = c_fd[j][31] ? 32'(-c_fd[j]) : 32'(c_fd[j]);
      d_side_next.tag.neg[j]     = mp[j][48];
      d_side_next.tag.neg[3 + j] = c_fd[j][31];
      d_side_next.mag[j]         = mp_abs[j][thrcol_pkg::MAG_W-1:0];
      d_side_next.mag[3 + j]     = thrcol_pkg::MAG_W'(fd_abs[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_rad  <= {c_s, 32'd0};
    d_side <= d_side_next;
  end

  // axis length with 16 fraction bits
  logic                          q_valid;
  logic [thrcol_pkg::ROOT_W-1:0] q_root;
  thrcol_pkg::sqside_t           q_side;

  thrcol_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .radicand (d_rad),
    .in_side  (d_side),
    .out_valid(q_valid),
    .root     (q_root),
    .out_side (q_side)
  );

  // stage e: rounding numerators 2*n + r over the divisor 2*r
  logic                                   e_valid;
  logic [NL-1:0][thrcol_pkg::NUM_W-1:0]   e_num;
  logic [thrcol_pkg::DEN_W-1:0]           e_den;
  thrcol_pkg::tag_t                       e_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= q_valid;
    end
    for (int j = 0; j < 3; j++) begin
      e_num[j] <= (thrcol_pkg::NUM_W'(q_side.mag[j]) << thrcol_pkg::MOM_SHIFT)
                  + thrcol_pkg::NUM_W'(q_root);
      e_num[3 + j] <= (thrcol_pkg::NUM_W'(q_side.mag[3 + j]) << thrcol_pkg::FRC_SHIFT)
                      + thrcol_pkg::NUM_W'(q_root);
    end
    e_den <= {q_root, 1'b0};
    e_tag <= q_side.tag;
  end

  logic                                 f_valid;
  logic [NL-1:0][thrcol_pkg::QUO_W-1:0] f_quo;
  thrcol_pkg::tag_t                     f_tag;

  thrcol_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (e_valid),
    .num      (e_num),
    .den      (e_den),
    .in_tag   (e_tag),
    .out_valid(f_valid),
    .quo      (f_quo),
    .out_tag  (f_tag)
  );

  // sign, clamp and zero the rows of unwritten columns
  logic [NL-1:0][31:0] row;

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      if (f_tag.status != thrcol_pkg::ST_WRITTEN) begin
        row[j] = '0;
      end else if (f_tag.neg[j]) begin
        row[j] = (f_quo[j] > 32'h8000_0000) ? 32'h8000_0000 : 32'(-f_quo[j]);
      end else begin
        row[j] = (f_quo[j] > 32'h7fff_ffff) ? 32'h7fff_ffff : f_quo[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_valid;
    end
    result.column   <= f_tag.column;
    result.status   <= f_tag.status;
    result.moment_x <= $signed(row[0]);
    result.moment_y <= $signed(row[1]);
    result.moment_z <= $signed(row[2]);
    result.force_x  <= $signed(row[3]);
    result.force_y  <= $signed(row[4]);
    result.force_z  <= $signed(row[5]);
  end

  // every transfer in gives its result a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("result missing at the expected latency");

  a_zero_rows: assert property (@(posedge clk) disable iff (rst)
    done && result.status != thrcol_pkg::ST_WRITTEN |->
      result.moment_x == '0 && result.moment_y == '0 && result.moment_z == '0 &&
      result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
    else $error("rows not zero for an unwritten column");

  a_force_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == thrcol_pkg::ST_WRITTEN |->
      result.force_x != '0 || result.force_y != '0 || result.force_z != '0)
    else $error("written column with zero thrust");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY  = 70;
  localparam int WD_LIMIT = 2000;
  localparam int NCOLS    = 16;
  localparam int NTHR     = 16;

  // column predictor and store of expected columns
  class column_board;
    thrcol_pkg::result_t pending[$];
    logic [4:0]          start_col;
    logic [4:0]          thr_count;
    int                  errors;

    function new();
      start_col = 0;
      thr_count = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [4:0] val);
      if (idx == thrcol_pkg::REG_START_COLUMN) start_col = val;
      else thr_count = val;
    endfunction

    function automatic longint unsigned axis_root(longint unsigned v);
      longint unsigned rem, root, b;
      rem  = v;
      root = 0;
      b    = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem  = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // round(a*b*2^sh/den), ties away from zero, clamped to 32 bits
    function automatic logic [31:0] scale_row(longint a, longint b, int sh,
                                              longint unsigned den);
      bit              neg;
      longint unsigned ma, mb, num, q;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      num = (ma * mb) << sh;
      q   = (2 * num + den) / (2 * den);
      if (neg) return (q > 64'd2147483648) ? 32'h8000_0000 : 32'(-q);
      return (q > 64'd2147483647) ? 32'h7fff_ffff : 32'(q);
    endfunction

    function void note_item(thrcol_pkg::item_t it);
      thrcol_pkg::result_t r;
      int unsigned         cnt, col;
      longint              px, py, pz, dx, dy, dz, cf, cx, cy, cz;
      longint unsigned     s, rt;
      r   = '0;
      cnt = (thr_count > NTHR) ? NTHR : thr_count;
      col = start_col + it.thruster_index;
      r.column = col[4:0];
      px = it.pos_x; py = it.pos_y; pz = it.pos_z;
      dx = it.dir_x; dy = it.dir_y; dz = it.dir_z;
      cf = it.coef;
      if (it.thruster_index >= cnt) r.status = thrcol_pkg::ST_BEYOND_CNT;
      else if (col >= NCOLS) r.status = thrcol_pkg::ST_BEYOND_COLS;
      else if (dx == 0 && dy == 0 && dz == 0) r.status = thrcol_pkg::ST_ZERO_AXIS;
      else if (cf == 0) r.status = thrcol_pkg::ST_ZERO_COEF;
      else begin
        r.status = thrcol_pkg::ST_WRITTEN;
        s  = dx * dx + dy * dy + dz * dz;
        rt = axis_root(s << 32);
        cx = py * dz - pz * dy;
        cy = pz * dx - px * dz;
        cz = px * dy - py * dx;
        r.moment_x = scale_row(cf, cx, 14, rt);
        r.moment_y = scale_row(cf, cy, 14, rt);
        r.moment_z = scale_row(cf, cz, 14, rt);
        r.force_x  = scale_row(cf, dx, 24, rt);
        r.force_y  = scale_row(cf, dy, 24, rt);
        r.force_z  = scale_row(cf, dz, 24, rt);
      end
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(thrcol_pkg::result_t got);
      thrcol_pkg::result_t e;
      if (pending.size() == 0) begin
        report("unexpected result, column", got.column, -1);
        return;
      end
      e = pending.pop_front();
      if (got.column !== e.column) report("column", got.column, e.column);
      if (got.status !== e.status) report("status", got.status, e.status);
      if (got.moment_x !== e.moment_x) report("moment_x", got.moment_x, e.moment_x);
      if (got.moment_y !== e.moment_y) report("moment_y", got.moment_y, e.moment_y);
      if (got.moment_z !== e.moment_z) report("moment_z", got.moment_z, e.moment_z);
      if (got.force_x !== e.force_x) report("force_x", got.force_x, e.force_x);
      if (got.force_y !== e.force_y) report("force_y", got.force_y, e.force_y);
      if (got.force_z !== e.force_z) report("force_z", got.force_z, e.force_z);
    endtask
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                start = 0;
  logic                busy;
  thrcol_pkg::item_t   item = '0;
  logic                done;
  thrcol_pkg::result_t result;
  logic                cfg_valid = 0;
  logic                cfg_ready;
  logic                cfg_index = 0;
  logic [4:0]          cfg_data = 0;

  column_board board = new();
  int          quiet_cycles = 0;
  bit          no_idle = 0;

  thruster_effectiveness_column_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // monitor transfers on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_item(item);
      if (done) board.check_result(result);
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // all drive tasks are entered and left at a rising edge
  task idle_gap();
    int n;
    if (!no_idle && $urandom_range(99) < 29) begin
      n = $urandom_range(1, 2);
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task send_item(thrcol_pkg::item_t it);
    bit b;
    idle_gap();
    start <= 1;
    item  <= it;
    forever begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
      if (!b) break;
    end
  endtask

  task drain();
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [4:0] val);
    bit r;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
      if (r) break;
    end
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick16(int mode);
    logic [15:0] edges[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
    if (mode == 0) return edges[$urandom_range(4)];
    if (mode == 1) return 16'($signed($urandom_range(0, 64)) - 32);
    return 16'($urandom);
  endfunction

  function automatic thrcol_pkg::item_t make_item(logic [4:0] cnt);
    thrcol_pkg::item_t it;
    int                m, c;
    m = $urandom_range(99);
    it.thruster_index = (cnt != 0 && $urandom_range(99) < 80) ?
                        4'($urandom_range(0, (cnt > NTHR ? NTHR : cnt) - 1)) :
                        4'($urandom);
    c = (m < 15) ? 0 : (m < 30) ? 1 : 2;
    it.pos_x = pick16(c); it.pos_y = pick16(c); it.pos_z = pick16(c);
    c = (m < 15) ? 0 : (m < 40) ? 1 : 2;
    it.dir_x = pick16(c); it.dir_y = pick16(c); it.dir_z = pick16(c);
    it.coef  = pick16((m < 20) ? 0 : 2);
    if ($urandom_range(99) < 8) {it.dir_x, it.dir_y, it.dir_z} = '0;
    if ($urandom_range(99) < 8) it.coef = 0;
    return it;
  endfunction

  function automatic thrcol_pkg::item_t mk(logic [3:0] ix, logic [15:0] p0,
                                           logic [15:0] p1, logic [15:0] p2,
                                           logic [15:0] d0, logic [15:0] d1,
                                           logic [15:0] d2, logic [15:0] cf);
    thrcol_pkg::item_t it;
    it = '{ix, p0, p1, p2, d0, d1, d2, cf};
    return it;
  endfunction

  logic [4:0] set_start[8] = '{5'd0, 5'd16, 5'd0, 5'd15, 5'd3, 5'd31, 5'd7, 5'd1};
  logic [4:0] set_count[8] = '{5'd16, 5'd16, 5'd31, 5'd1, 5'd0, 5'd16, 5'd9, 5'd20};

  initial begin
    int         k, p;
    logic [4:0] cnt;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: start 8, count 12
    write_reg(thrcol_pkg::REG_START_COLUMN, 5'd8);
    write_reg(thrcol_pkg::REG_THRUSTER_COUNT, 5'd12);
    send_item(mk(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(mk(1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_item(mk(2, 16'h7fff, 16'h8000, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0100));
    send_item(mk(3, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h8000));
    send_item(mk(4, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h7fff));
    send_item(mk(5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100));
    send_item(mk(6, 16'h1234, 16'h5678, 16'h9abc, 16'h1000, 16'h1000, 16'h1000, 16'h0000));
    send_item(mk(7, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff));
    send_item(mk(8, 16'h0400, 16'h0400, 16'h0400, 16'h1000, 16'h0000, 16'h0000, 16'h0100));
    send_item(mk(9, 16'h0400, 16'h0400, 16'h0400, 16'h1000, 16'h0000, 16'h0000, 16'h0100));
    send_item(mk(11, 16'h0400, 16'h0400, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(12, 16'h0400, 16'h0400, 16'h0400, 16'h1000, 16'h0000, 16'h0000, 16'h0100));
    send_item(mk(15, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(mk(0, 16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001, 16'h0001));
    send_item(mk(1, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h8000));
    drain();

    // random phases over several register settings
    for (p = 0; p < 8; p++) begin
      write_reg(thrcol_pkg::REG_START_COLUMN, set_start[p]);
      write_reg(thrcol_pkg::REG_THRUSTER_COUNT, set_count[p]);
      cnt = set_count[p];
      for (k = 0; k < 125; k++) begin
        no_idle = (p == 2);
        send_item(make_item(cnt));
      end
      no_idle = 0;
      drain();
    end

    if (board.pending.size() != 0)
      board.report("results missing", board.pending.size(), 0);
    if (board.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
